// ===== rtl/binary_min_heap_queue_core_defines.svh =====
// Assertion macros shared by the priority queue RTL.
`ifndef BINARY_MIN_HEAP_QUEUE_CORE_DEFINES_SVH
`define BINARY_MIN_HEAP_QUEUE_CORE_DEFINES_SVH

// Checked on every rising edge, reset included.
`define BMHQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// Checked on every rising edge outside reset.
`define BMHQ_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// ===== rtl/bmhq_pkg.sv =====
// Types and constants of the priority queue.
package bmhq_pkg;

  localparam int KEY_W = 32;
  localparam int CAP_W = 6;

  // Reset value of the capacity register.
  localparam logic [CAP_W-1:0] CAP_RESET = 6'd20;

  // Command codes.
  localparam logic CMD_INSERT  = 1'b0;
  localparam logic CMD_EXTRACT = 1'b1;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Operation broadcast to every cell.
  typedef enum logic [1:0] {
    OP_HOLD    = 2'd0,
    OP_INSERT  = 2'd1,
    OP_EXTRACT = 2'd2
  } cell_op_t;

  typedef struct packed {
    cell_op_t                 op;
    logic signed [KEY_W-1:0]  key;
  } cell_ctrl_t;

endpackage

// ===== rtl/binary_min_heap_queue_core.sv =====
// Top level of the priority queue: a sorted chain of key cells with a fill counter.
//
//  Channel   Ports                                        Transfer
//  command   start, busy, command, key_value              start && !busy
//  result    done, min_value, status, element_count       done (one cycle, no stall)
//  config    capacity_we, capacity_limit                  capacity_we
//
// Each result shows on the cycle after its transfer, so a new item may follow
// in every cycle. Each cell of the chain makes one 32-bit compare per item and
// takes a key from a neighbor or the new key, or keeps its own.
// busy is high only during reset; reset empties the queue and sets the capacity to 20.
// The receiver cannot stall, so results are never held.
`include "binary_min_heap_queue_core_defines.svh"

module binary_min_heap_queue_core #(
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   command,
  input  logic signed [bmhq_pkg::KEY_W-1:0]      key_value,
  input  logic                                   capacity_we,
  input  logic [bmhq_pkg::CAP_W-1:0]             capacity_limit,
  output logic                                   done,
  output logic signed [bmhq_pkg::KEY_W-1:0]      min_value,
  output logic [1:0]                             status,
  output logic [$clog2(DEPTH+1)-1:0]             element_count
);

  localparam int CW    = $clog2(DEPTH + 1);
  localparam int CMP_W = ((CW > bmhq_pkg::CAP_W) ? CW : bmhq_pkg::CAP_W) + 1;

  logic [bmhq_pkg::CAP_W-1:0]         cap_limit;
  logic [CW-1:0]                      count;
  logic [CW-1:0]                      count_next;
  logic                               accept;
  logic                               full;
  logic                               empty;
  logic [CMP_W-1:0]                   cap_ext;
  logic [CMP_W-1:0]                   eff_cap;
  bmhq_pkg::cell_ctrl_t               ctrl;
  logic [DEPTH-1:0]                   occ;
  logic [DEPTH-1:0]                   gts;
  logic signed [bmhq_pkg::KEY_W-1:0]  vals [DEPTH];

  assign busy   = rst;
  assign accept = start && !busy;

  // Capacity register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_limit <= bmhq_pkg::CAP_RESET;
    end else if (capacity_we) begin
      cap_limit <= capacity_limit;
    end
  end

  // Capacity saturates at the chain length.
  assign cap_ext = CMP_W'(cap_limit);
  assign eff_cap = (cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext;
  assign full    = (CMP_W'(count) >= eff_cap);
  assign empty   = (count == '0);

  // Operation for the chain and the new fill count.
  always_comb begin
    ctrl.key   = key_value;
    ctrl.op    = bmhq_pkg::OP_HOLD;
    count_next = count;
    if (accept) begin
      if (command == bmhq_pkg::CMD_INSERT) begin
        if (!full) begin
          ctrl.op    = bmhq_pkg::OP_INSERT;
          count_next = count + CW'(1);
        end
      end else begin
        if (!empty) begin
          ctrl.op    = bmhq_pkg::OP_EXTRACT;
          count_next = count - CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Chain of cells; the leftmost holds the smallest key.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [bmhq_pkg::KEY_W-1:0] left_val;
    logic                              left_gt;
    logic signed [bmhq_pkg::KEY_W-1:0] right_val;

    assign occ[i] = (count > CW'(i));

    if (i == 0) begin : g_first
      assign left_val = '0;
      assign left_gt  = 1'b0;
    end else begin : g_inner
      assign left_val = vals[i-1];
      assign left_gt  = gts[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_body
      assign right_val = vals[i+1];
    end

    bmhq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occ       (occ[i]),
      .left_val  (left_val),
      .left_gt   (left_gt),
      .right_val (right_val),
      .val       (vals[i]),
      .gt        (gts[i])
    );
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= accept;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      element_count <= count_next;
      min_value     <= '0;
      status        <= bmhq_pkg::ST_OK;
      if (command == bmhq_pkg::CMD_INSERT) begin
        if (full) begin
          status <= bmhq_pkg::ST_FULL;
        end
      end else begin
        if (empty) begin
          status <= bmhq_pkg::ST_EMPTY;
        end else begin
          min_value <= vals[0];
        end
      end
    end
  end

  // The fill count never passes the chain length.
  `BMHQ_ASSERT_RUN(a_count_bound, count <= CW'(DEPTH), "fill count exceeds depth")

  // Every transfer gives a result on the next cycle.
  `BMHQ_ASSERT(a_result_follows, accept |=> done, "missing result after transfer")

  // A reported count matches the queue's fill.
  `BMHQ_ASSERT_RUN(a_count_match, done |-> element_count == count, "count mismatch")

  // An error leaves the fill count unchanged.
  `BMHQ_ASSERT_RUN(a_error_holds, accept && ctrl.op == bmhq_pkg::OP_HOLD |=> $stable(count),
                   "fill changed on error")

  // Held keys stay in ascending order along the chain.
  for (genvar j = 1; j < DEPTH; j++) begin : g_order
    `BMHQ_ASSERT_RUN(a_sorted, occ[j] |-> !(vals[j] < vals[j-1]), "chain out of order")
  end

endmodule

// ===== rtl/bmhq_cell.sv =====
// One slot of the sorted key chain.
module bmhq_cell (
  input  logic                             clk,
  input  bmhq_pkg::cell_ctrl_t             ctrl,
  input  logic                             occ,
  input  logic signed [bmhq_pkg::KEY_W-1:0] left_val,
  input  logic                             left_gt,
  input  logic signed [bmhq_pkg::KEY_W-1:0] right_val,
  output logic signed [bmhq_pkg::KEY_W-1:0] val,
  output logic                             gt
);

  logic signed [bmhq_pkg::KEY_W-1:0] val_next;

  // The new key belongs at or before this slot when the slot is free or holds a larger key.
  assign gt = !occ || (ctrl.key < val);

  // Insert shifts larger keys one slot right; extract shifts every key one slot left.
  always_comb begin
    val_next = val;
    unique case (ctrl.op)
      bmhq_pkg::OP_INSERT: begin
        if (left_gt) begin
          val_next = left_val;
        end else if (gt) begin
          val_next = ctrl.key;
        end
      end
      bmhq_pkg::OP_EXTRACT: begin
        val_next = right_val;
      end
      bmhq_pkg::OP_HOLD: begin
        val_next = val;
      end
      default: begin
        val_next = val;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule
